/* hw/rtl/mcp_pkg.sv */
// shared types, codes and constants of the motion command parser
package mcp_pkg;

  // widths fixed by the interface
  localparam int unsigned LimitW = 20;
  localparam int unsigned IdleW  = 21;
  localparam int unsigned ValW   = 32;
  localparam int unsigned WideW  = 37;

  localparam logic [LimitW-1:0] IdleLimitRst = LimitW'(1000);
  localparam logic [IdleW-1:0]  IdleMax      = '1;

  // command codes
  localparam logic CmdByte = 1'b0;
  localparam logic CmdPoll = 1'b1;

  // characters of the command language
  localparam logic [7:0] ChBang  = 8'h21;  // '!'
  localparam logic [7:0] ChStar  = 8'h2A;  // '*'
  localparam logic [7:0] ChPlus  = 8'h2B;  // '+'
  localparam logic [7:0] ChMinus = 8'h2D;  // '-'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChB     = 8'h42;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChL     = 8'h4C;
  localparam logic [7:0] ChW     = 8'h57;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChY     = 8'h59;
  localparam logic [7:0] ChZ     = 8'h5A;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WALK,
    KIND_DANCE,
    KIND_LEG
  } kind_t;

  typedef enum logic [3:0] {
    FLD_NONE,
    FLD_LEG,
    FLD_GAIT,
    FLD_X,
    FLD_Y,
    FLD_Z,
    FLD_YAW,
    FLD_PITCH,
    FLD_ROLL
  } field_t;

  typedef enum logic [2:0] {
    ACT_WALK,
    ACT_DANCE,
    ACT_LEG,
    ACT_GAIT,
    ACT_FREEZE
  } action_t;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
    logic       data_waiting;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           action;
    logic [3:0]           gait_digit;
    logic [3:0]           leg_number;
    logic signed [ValW-1:0] pos_x;
    logic signed [ValW-1:0] pos_y;
    logic signed [ValW-1:0] pos_z;
    logic signed [ValW-1:0] yaw_value;
    logic signed [ValW-1:0] pitch_value;
    logic signed [ValW-1:0] roll_value;
  } out_item_t;

endpackage

/* hw/rtl/mcp_accum.sv */
// saturating decimal digit accumulator: acc * 10 +/- digit
module mcp_accum (
  input  logic signed [mcp_pkg::ValW-1:0] acc,
  input  logic [3:0]                      digit,
  input  logic                            neg,
  output logic signed [mcp_pkg::ValW-1:0] acc_nxt
);

  logic signed [mcp_pkg::WideW-1:0] ext;
  logic signed [mcp_pkg::WideW-1:0] times10;
  logic signed [mcp_pkg::WideW-1:0] sum;
  logic signed [mcp_pkg::WideW-1:0] dig_ext;

  // times ten as two shifts and an add
  assign ext     = mcp_pkg::WideW'(acc);
  assign times10 = (ext <<< 3) + (ext <<< 1);
  assign dig_ext = mcp_pkg::WideW'($unsigned(digit));
  assign sum     = neg ? (times10 - dig_ext) : (times10 + dig_ext);

  // clamp to the 32-bit signed range
  always_comb begin
    if (sum[mcp_pkg::WideW-1:mcp_pkg::ValW-1] == '0 ||
        sum[mcp_pkg::WideW-1:mcp_pkg::ValW-1] == '1) begin
      acc_nxt = sum[mcp_pkg::ValW-1:0];
    end else if (sum[mcp_pkg::WideW-1]) begin
      acc_nxt = {1'b1, {(mcp_pkg::ValW-1){1'b0}}};
    end else begin
      acc_nxt = {1'b0, {(mcp_pkg::ValW-1){1'b1}}};
    end
  end

endmodule

/* hw/rtl/mcp_parser.sv */
// parser state, idle counter and result formation for one item
module mcp_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [mcp_pkg::LimitW-1:0] cfg_wdata,
  input  logic                       fire,
  input  mcp_pkg::in_item_t          item,
  output logic                       res_valid,
  output mcp_pkg::out_item_t         res
);

  mcp_pkg::kind_t                kind_r, kind_nxt;
  mcp_pkg::field_t               field_r, field_nxt;
  logic                          neg_r, neg_nxt;
  logic [3:0]                    leg_r, leg_nxt;
  logic signed [mcp_pkg::ValW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [mcp_pkg::ValW-1:0] yaw_r, yaw_nxt, pitch_r, pitch_nxt;
  logic signed [mcp_pkg::ValW-1:0] roll_r, roll_nxt;
  logic [mcp_pkg::IdleW-1:0]     idle_r, idle_nxt;
  logic [mcp_pkg::LimitW-1:0]    limit_r;

  logic                          is_digit;
  logic [3:0]                    digit;
  logic signed [mcp_pkg::ValW-1:0] acc_sel, acc_new;

  assign is_digit = (item.byte_value >= mcp_pkg::ChZero) &&
                    (item.byte_value <= mcp_pkg::ChNine);
  assign digit    = 4'(item.byte_value - mcp_pkg::ChZero);

  // pick the open field for the shared accumulator
  always_comb begin
    unique case (field_r)
      mcp_pkg::FLD_X:     acc_sel = x_r;
      mcp_pkg::FLD_Y:     acc_sel = y_r;
      mcp_pkg::FLD_Z:     acc_sel = z_r;
      mcp_pkg::FLD_YAW:   acc_sel = yaw_r;
      mcp_pkg::FLD_PITCH: acc_sel = pitch_r;
      mcp_pkg::FLD_ROLL:  acc_sel = roll_r;
      default:            acc_sel = x_r;
    endcase
  end

  mcp_accum u_accum (
    .acc     (acc_sel),
    .digit   (digit),
    .neg     (neg_r),
    .acc_nxt (acc_new)
  );

  // next state and result
  always_comb begin
    kind_nxt  = kind_r;
    field_nxt = field_r;
    neg_nxt   = neg_r;
    leg_nxt   = leg_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    yaw_nxt   = yaw_r;
    pitch_nxt = pitch_r;
    roll_nxt  = roll_r;
    idle_nxt  = idle_r;
    res_valid = 1'b0;
    res       = '0;

    if (item.command == mcp_pkg::CmdPoll) begin
      // poll tick: idle counting and freeze
      if (item.data_waiting) begin
        idle_nxt = '0;
      end else begin
        if (idle_r != mcp_pkg::IdleMax) begin
          idle_nxt = idle_r + 1'b1;
        end
        if (idle_nxt > mcp_pkg::IdleW'(limit_r)) begin
          res_valid  = 1'b1;
          res.action = mcp_pkg::ACT_FREEZE;
        end
      end
    end else begin
      unique case (item.byte_value)
        mcp_pkg::ChBang: begin
          kind_nxt  = mcp_pkg::KIND_NONE;
          field_nxt = mcp_pkg::FLD_NONE;
          neg_nxt   = 1'b0;
          leg_nxt   = '0;
          x_nxt     = '0;
          y_nxt     = '0;
          z_nxt     = '0;
          yaw_nxt   = '0;
          pitch_nxt = '0;
          roll_nxt  = '0;
        end
        mcp_pkg::ChW: kind_nxt = mcp_pkg::KIND_WALK;
        mcp_pkg::ChD: kind_nxt = mcp_pkg::KIND_DANCE;
        mcp_pkg::ChL: begin
          kind_nxt  = mcp_pkg::KIND_LEG;
          field_nxt = mcp_pkg::FLD_LEG;
        end
        mcp_pkg::ChG: field_nxt = mcp_pkg::FLD_GAIT;
        mcp_pkg::ChX: begin
          field_nxt = mcp_pkg::FLD_X;
          x_nxt     = '0;
          neg_nxt   = 1'b0;
        end
        mcp_pkg::ChY: begin
          field_nxt = mcp_pkg::FLD_Y;
          y_nxt     = '0;
          neg_nxt   = 1'b0;
        end
        mcp_pkg::ChZ: begin
          field_nxt = mcp_pkg::FLD_Z;
          z_nxt     = '0;
          neg_nxt   = 1'b0;
        end
        mcp_pkg::ChA: begin
          field_nxt = mcp_pkg::FLD_YAW;
          yaw_nxt   = '0;
          neg_nxt   = 1'b0;
        end
        mcp_pkg::ChB: begin
          field_nxt = mcp_pkg::FLD_PITCH;
          pitch_nxt = '0;
          neg_nxt   = 1'b0;
        end
        mcp_pkg::ChC: begin
          field_nxt = mcp_pkg::FLD_ROLL;
          roll_nxt  = '0;
          neg_nxt   = 1'b0;
        end
        mcp_pkg::ChMinus: neg_nxt = 1'b1;
        mcp_pkg::ChPlus:  neg_nxt = 1'b0;
        mcp_pkg::ChStar: begin
          // emit the command for the chosen control kind
          if (kind_r != mcp_pkg::KIND_NONE) begin
            res_valid = 1'b1;
            res.pos_x = x_r;
            res.pos_y = y_r;
            res.pos_z = z_r;
            unique case (kind_r)
              mcp_pkg::KIND_WALK: begin
                res.action    = mcp_pkg::ACT_WALK;
                res.yaw_value = yaw_r;
              end
              mcp_pkg::KIND_DANCE: begin
                res.action      = mcp_pkg::ACT_DANCE;
                res.yaw_value   = yaw_r;
                res.pitch_value = pitch_r;
                res.roll_value  = roll_r;
              end
              default: begin
                res.action     = mcp_pkg::ACT_LEG;
                res.leg_number = leg_r;
              end
            endcase
          end
        end
        default: begin
          // digit into the open field
          if (is_digit) begin
            unique case (field_r)
              mcp_pkg::FLD_LEG: leg_nxt = digit;
              mcp_pkg::FLD_GAIT: begin
                res_valid      = 1'b1;
                res.action     = mcp_pkg::ACT_GAIT;
                res.gait_digit = digit;
              end
              mcp_pkg::FLD_X:     x_nxt     = acc_new;
              mcp_pkg::FLD_Y:     y_nxt     = acc_new;
              mcp_pkg::FLD_Z:     z_nxt     = acc_new;
              mcp_pkg::FLD_YAW:   yaw_nxt   = acc_new;
              mcp_pkg::FLD_PITCH: pitch_nxt = acc_new;
              mcp_pkg::FLD_ROLL:  roll_nxt  = acc_new;
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= mcp_pkg::KIND_NONE;
      field_r <= mcp_pkg::FLD_NONE;
      neg_r   <= 1'b0;
      leg_r   <= '0;
      x_r     <= '0;
      y_r     <= '0;
      z_r     <= '0;
      yaw_r   <= '0;
      pitch_r <= '0;
      roll_r  <= '0;
      idle_r  <= '0;
    end else if (fire) begin
      kind_r  <= kind_nxt;
      field_r <= field_nxt;
      neg_r   <= neg_nxt;
      leg_r   <= leg_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
      idle_r  <= idle_nxt;
    end
  end

  // idle limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mcp_pkg::IdleLimitRst;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

endmodule

/* hw/rtl/motion_command_parser_with_timeout.sv */
// top level: input register, parser and result register
// Text motion command parser. Each transfer on the input channel is a received byte or a
// poll tick; a result (walk, dance, leg move, gait change or freeze) is loaded into the
// result register at the edge at which its item leaves the input register. One item is
// parsed per cycle while the result register is empty or being taken; the single decimal
// accumulate unit (times ten plus or minus digit, saturating) sits between the input
// register and the result register. An item waits in the input register while the result
// register is full and not being taken, whether or not the item makes a result.
// Reset values: idle limit 1000, all fields zero, no field open. No clearing pass.
module motion_command_parser_with_timeout (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mcp_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mcp_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [mcp_pkg::LimitW-1:0] cfg_wdata
);

  logic               in_valid_r;
  mcp_pkg::in_item_t  in_item_r;
  logic               out_valid_r;
  mcp_pkg::out_item_t out_item_r;
  logic               fire;
  logic               res_valid;
  mcp_pkg::out_item_t res;

  // the held item is parsed when the result register can take its result
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  mcp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (in_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

/* tb/tb_motion_command_parser_with_timeout.sv */
// testbench for the motion command parser with idle timeout
`timescale 1ns / 1ps

module tb_motion_command_parser_with_timeout;
  import mcp_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam longint AccMax = 64'sd2147483647;
  localparam longint AccMin = -64'sd2147483648;

  // tracks parser state and the commands it must produce, in order
  class motion_shadow;
    logic [LimitW-1:0] idle_limit = IdleLimitRst;
    logic [IdleW-1:0] idle_ticks = '0;
    kind_t kind = KIND_NONE;
    field_t open_fld = FLD_NONE;
    logic negative = 1'b0;
    logic [3:0] leg = '0;
    logic signed [ValW-1:0] acc [6] = '{default: '0};
    out_item_t expected_cmds [$];
    int mismatches = 0;

    // accumulator slot of a signed field, x first and roll last
    function int slot(field_t f);
      return int'(f) - int'(FLD_X);
    endfunction

    function void clear_all();
      kind = KIND_NONE;
      open_fld = FLD_NONE;
      negative = 1'b0;
      leg = '0;
      acc = '{default: '0};
    endfunction

    function void open_value(field_t f);
      open_fld = f;
      acc[slot(f)] = '0;
      negative = 1'b0;
    endfunction

    // times ten plus or minus the digit, clamped to 32-bit signed range
    function logic signed [ValW-1:0] times_ten(logic signed [ValW-1:0] a, logic [3:0] d);
      longint v;
      v = longint'(a) * 10;
      v = negative ? v - longint'(d) : v + longint'(d);
      if (v > AccMax) v = AccMax;
      if (v < AccMin) v = AccMin;
      return ValW'(v);
    endfunction

    function void take_item(in_item_t it);
      out_item_t cmd;
      logic [3:0] d;
      cmd = '0;
      // poll tick: idle counting and freeze
      if (it.command == CmdPoll) begin
        if (it.data_waiting) begin
          idle_ticks = '0;
        end else begin
          if (idle_ticks != IdleMax) idle_ticks++;
          if (idle_ticks > {1'b0, idle_limit}) begin
            cmd.action = ACT_FREEZE;
            expected_cmds.push_back(cmd);
          end
        end
        return;
      end
      // received byte
      case (it.byte_value)
        ChBang: clear_all();
        ChW: kind = KIND_WALK;
        ChD: kind = KIND_DANCE;
        ChL: begin
          kind = KIND_LEG;
          open_fld = FLD_LEG;
        end
        ChG: open_fld = FLD_GAIT;
        ChX: open_value(FLD_X);
        ChY: open_value(FLD_Y);
        ChZ: open_value(FLD_Z);
        ChA: open_value(FLD_YAW);
        ChB: open_value(FLD_PITCH);
        ChC: open_value(FLD_ROLL);
        ChMinus: negative = 1'b1;
        ChPlus: negative = 1'b0;
        ChStar: begin
          if (kind != KIND_NONE) begin
            cmd.pos_x = acc[slot(FLD_X)];
            cmd.pos_y = acc[slot(FLD_Y)];
            cmd.pos_z = acc[slot(FLD_Z)];
            case (kind)
              KIND_WALK: begin
                cmd.action = ACT_WALK;
                cmd.yaw_value = acc[slot(FLD_YAW)];
              end
              KIND_DANCE: begin
                cmd.action = ACT_DANCE;
                cmd.yaw_value = acc[slot(FLD_YAW)];
                cmd.pitch_value = acc[slot(FLD_PITCH)];
                cmd.roll_value = acc[slot(FLD_ROLL)];
              end
              default: begin
                cmd.action = ACT_LEG;
                cmd.leg_number = leg;
              end
            endcase
            expected_cmds.push_back(cmd);
          end
        end
        default: begin
          if (it.byte_value >= ChZero && it.byte_value <= ChNine) begin
            d = 4'(it.byte_value - ChZero);
            case (open_fld)
              FLD_NONE: ;
              FLD_LEG: leg = d;
              FLD_GAIT: begin
                cmd.action = ACT_GAIT;
                cmd.gait_digit = d;
                expected_cmds.push_back(cmd);
              end
              default: acc[slot(open_fld)] = times_ten(acc[slot(open_fld)], d);
            endcase
          end
        end
      endcase
    endfunction

    function void compare(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_cmd(out_item_t got);
      out_item_t want;
      if (expected_cmds.size() == 0) begin
        $error("command transfer with none expected: action %0d", got.action);
        mismatches++;
        return;
      end
      want = expected_cmds.pop_front();
      compare("action", longint'(want.action), longint'(got.action));
      compare("gait_digit", longint'(want.gait_digit), longint'(got.gait_digit));
      compare("leg_number", longint'(want.leg_number), longint'(got.leg_number));
      compare("pos_x", longint'(want.pos_x), longint'(got.pos_x));
      compare("pos_y", longint'(want.pos_y), longint'(got.pos_y));
      compare("pos_z", longint'(want.pos_z), longint'(got.pos_z));
      compare("yaw_value", longint'(want.yaw_value), longint'(got.yaw_value));
      compare("pitch_value", longint'(want.pitch_value), longint'(got.pitch_value));
      compare("roll_value", longint'(want.roll_value), longint'(got.roll_value));
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [LimitW-1:0] cfg_wdata = '0;

  motion_shadow shadow;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int unsigned quiet_cycles = 0;

  motion_command_parser_with_timeout dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // check result transfers and watch for a hang, sampled mid-cycle
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) shadow.check_cmd(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send(in_item_t it);
    logic took;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    shadow.take_item(it);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it.command = CmdByte;
    it.byte_value = b;
    it.data_waiting = 1'($urandom_range(0, 1));
    send(it);
  endtask

  task automatic send_poll(logic waiting);
    in_item_t it;
    it.command = CmdPoll;
    it.byte_value = 8'($urandom_range(0, 255));
    it.data_waiting = waiting;
    send(it);
  endtask

  task automatic send_digit();
    send_byte(ChZero + 8'($urandom_range(0, 9)));
  endtask

  // optional sign then digits; long runs push into saturation
  task automatic send_number();
    int n;
    case ($urandom_range(0, 3))
      0: send_byte(ChMinus);
      1: send_byte(ChPlus);
      default: ;
    endcase
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
    repeat (n) send_digit();
  endtask

  // a command: optional clear, optional kind, some fields and gait requests, then stop
  task automatic send_sentence();
    if ($urandom_range(0, 1)) send_byte(ChBang);
    case ($urandom_range(0, 9))
      0: ;
      1, 2, 3: send_byte(ChW);
      4, 5, 6: send_byte(ChD);
      default: begin
        send_byte(ChL);
        send_digit();
      end
    endcase
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 6))
        0: send_byte(ChX);
        1: send_byte(ChY);
        2: send_byte(ChZ);
        3: send_byte(ChA);
        4: send_byte(ChB);
        5: send_byte(ChC);
        default: send_byte(ChG);
      endcase
      if (shadow.open_fld == FLD_GAIT) repeat ($urandom_range(1, 2)) send_digit();
      else send_number();
    end
    send_byte(ChStar);
  endtask

  // stop sending and let every expected command and any in-flight item drain
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (shadow.expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idle_limit(logic [LimitW-1:0] v);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.idle_limit = v;
  endtask

  // directed sequence, run with an idle limit of two
  task automatic run_directed();
    repeat (4) send_poll(1'b0);  // third and fourth tick freeze
    send_poll(1'b1);             // data waiting clears the idle count
    send_byte(ChStar);           // stop with no control kind
    send_byte(ChZero + 8'd5);    // digit with no field open
    send_byte(ChW);
    send_byte(ChX);
    send_byte(ChMinus);
    send_byte(ChNine);
    send_byte(ChStar);
    send_byte(ChStar);           // fields kept after a stop
    send_byte(ChG);
    send_byte(ChZero + 8'd7);
    send_byte(ChZero);
    send_byte(ChL);
    send_byte(ChNine);
    send_byte(ChStar);
    send_byte("?");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(ChBang);
    send_byte(ChD);
    send_byte(ChStar);
  endtask

  task automatic run_random(int count);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_sentence();
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_poll($urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
          else send_digit();
        end
      end
    end
  endtask

  initial begin
    shadow = new;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_idle_limit(LimitW'(2));
    run_directed();

    send_idle_pct = 24;
    recv_idle_pct = 52;
    set_idle_limit(LimitW'(5));
    run_random(400);

    send_idle_pct = 52;
    recv_idle_pct = 24;
    set_idle_limit('1);
    run_random(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_idle_limit('0);
    run_random(400);

    wait_drain();
    if (shadow.mismatches == 0 && shadow.expected_cmds.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mcp_pkg.sv
hw/rtl/mcp_accum.sv
hw/rtl/mcp_parser.sv
hw/rtl/motion_command_parser_with_timeout.sv
tb/tb_motion_command_parser_with_timeout.sv
